@@ hdl/dss_pkg.sv @@
`default_nettype none
package dss_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ENERGY_W    = 32;
  localparam int PROB_W      = 16;
  localparam int UNI_W       = 16;
  localparam int SUM_W       = 22;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int HELD_W      = 7;

  localparam int S_TDATA_W   = ((ENERGY_W + PROB_W + UNI_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((ENERGY_W + HELD_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  // how the datapath fills the pending result
  typedef enum logic [1:0] {
    RES_OK,
    RES_FULL,
    RES_NO_MATCH,
    RES_HIT
  } res_t;

  typedef struct packed {
    logic capture;
    logic clear_count;
    logic load_start;
    logic sample_start;
    logic rd_prev;
    logic rd_cur;
    logic wr_shift;
    logic wr_insert;
    logic samp_step;
    logic set_res;
    res_t res_kind;
    logic push;
  } dss_cmd_t;

  typedef struct packed {
    op_t  op;
    logic table_full;
    logic table_empty;
    logic idx_zero;
    logic idx_last;
    logic shift_needed;
    logic hit;
    logic out_busy;
  } dss_sts_t;

endpackage
`default_nettype wire

@@ hdl/dss_datapath.sv @@
`default_nettype none
module dss_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dss_pkg::dss_cmd_t              cmd,
  output dss_pkg::dss_sts_t                   sts,
  input  wire logic [dss_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic [dss_pkg::OP_W-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [dss_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic      [dss_pkg::STATUS_W-1:0]   m_tuser
);
  import dss_pkg::*;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PROB_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // sorted spectrum table
  logic [ENERGY_W-1:0] mem_energy [TABLE_DEPTH];
  logic [SUM_W-1:0]    mem_sum    [TABLE_DEPTH];
  logic [ENERGY_W-1:0] rd_energy;
  logic [SUM_W-1:0]    rd_sum;

  // request being worked on
  op_t                 op_r;
  logic [ENERGY_W-1:0] energy_r;
  logic [PROB_W-1:0]   prob_r;
  logic [UNI_W-1:0]    uni_r;

  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    idx;

  logic [ENERGY_W-1:0] res_energy;
  status_t             res_status;

  logic [ENERGY_W-1:0] m_energy;
  status_t             m_status;
  logic [HELD_W-1:0]   m_held;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [ENERGY_W-1:0] wr_energy;
  logic [SUM_W-1:0]    wr_sum;
  logic [SUM_W-1:0]    base_sum;

  assign rd_en     = cmd.rd_prev | cmd.rd_cur;
  assign rd_addr   = cmd.rd_prev ? (idx - IDX_W'(1)) : idx;
  assign wr_en     = cmd.wr_shift | cmd.wr_insert;
  assign wr_energy = cmd.wr_shift ? rd_energy : energy_r;
  // a new pair at the head starts from an empty running sum
  assign base_sum  = (cmd.wr_insert && idx == '0) ? '0 : rd_sum;
  assign wr_sum    = sat_add(base_sum, prob_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_energy[idx] <= wr_energy;
      mem_sum[idx]    <= wr_sum;
    end
    if (rd_en) begin
      rd_energy <= mem_energy[rd_addr];
      rd_sum    <= mem_sum[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(s_tuser);
      energy_r <= s_tdata[ENERGY_W-1:0];
      prob_r   <= s_tdata[ENERGY_W +: PROB_W];
      uni_r    <= s_tdata[ENERGY_W+PROB_W +: UNI_W];
    end
    if (cmd.load_start) begin
      idx <= IDX_W'(count);
    end else if (cmd.sample_start) begin
      idx <= '0;
    end else if (cmd.wr_shift) begin
      idx <= idx - IDX_W'(1);
    end else if (cmd.samp_step) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.set_res) begin
      case (cmd.res_kind)
        RES_FULL: begin
          res_energy <= '0;
          res_status <= ST_FULL;
        end
        RES_NO_MATCH: begin
          res_energy <= '0;
          res_status <= ST_NO_MATCH;
        end
        RES_HIT: begin
          res_energy <= rd_energy;
          res_status <= ST_OK;
        end
        default: begin
          res_energy <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
    if (cmd.push) begin
      m_energy <= res_energy;
      m_status <= res_status;
      m_held   <= HELD_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.wr_insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W-ENERGY_W-HELD_W){1'b0}}, m_held, m_energy};
  assign m_tuser = m_status;

  assign sts.op           = op_r;
  assign sts.table_full   = (count == CNT_W'(TABLE_DEPTH));
  assign sts.table_empty  = (count == '0);
  assign sts.idx_zero     = (idx == '0);
  assign sts.idx_last     = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign sts.shift_needed = (rd_energy > energy_r);
  assign sts.hit          = (rd_sum > SUM_W'(uni_r));
  assign sts.out_busy     = m_tvalid & ~m_tready;

endmodule
`default_nettype wire

@@ hdl/dss_ctrl.sv @@
`default_nettype none
module dss_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output dss_pkg::dss_cmd_t cmd,
  input  wire dss_pkg::dss_sts_t sts
);
  import dss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LD_RD,
    S_LD_CMP,
    S_SM_RD,
    S_SM_CHK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        state_next  = S_FINISH;
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd.res_kind    = RES_OK;
          end
          OP_LOAD: begin
            if (sts.table_full) begin
              cmd.res_kind = RES_FULL;
            end else begin
              cmd.set_res    = 1'b0;
              cmd.load_start = 1'b1;
              state_next     = S_LD_RD;
            end
          end
          OP_SAMPLE: begin
            if (sts.table_empty) begin
              cmd.res_kind = RES_NO_MATCH;
            end else begin
              cmd.set_res      = 1'b0;
              cmd.sample_start = 1'b1;
              state_next       = S_SM_RD;
            end
          end
          default: cmd.res_kind = RES_OK;
        endcase
      end
      S_LD_RD: begin
        // at the head: nothing below to compare against
        if (sts.idx_zero) begin
          cmd.wr_insert = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_kind  = RES_OK;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        if (sts.shift_needed) begin
          cmd.wr_shift = 1'b1;
          state_next   = S_LD_RD;
        end else begin
          cmd.wr_insert = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_kind  = RES_OK;
          state_next    = S_FINISH;
        end
      end
      S_SM_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_SM_CHK;
      end
      S_SM_CHK: begin
        if (sts.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_HIT;
          state_next   = S_FINISH;
        end else if (sts.idx_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_NO_MATCH;
          state_next   = S_FINISH;
        end else begin
          cmd.samp_step = 1'b1;
          state_next    = S_SM_RD;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/discrete_spectrum_sampler.sv @@
// Inverse-CDF sampler over a discrete energy spectrum of up to TABLE_DEPTH
// (energy, probability) pairs. Each request on the slave stream carries an
// operation in s_tuser: clear empties the table, load inserts one pair at its
// sorted place (after equal energies) and adds its probability to the running
// sum of that entry and all later ones, saturating at 2^22-1, and sample
// returns the energy of the first entry whose running sum exceeds the uniform
// draw. Every request gives exactly one result on the master stream, with the
// status (ok, table_full, no_match) in m_tuser and the entry count after the
// request, masked to 7 bits, beside the energy. One request is worked on at a
// time, through a table memory with one write and one registered read port:
// a load moves each entry above its sorted place up with one read and one
// write, and a sample steps through the entries from the head until one
// matches, so a miss scans every held entry. A result waiting on m_tready
// holds the next request back only once it is itself ready to be written
// to the output register.
`default_nettype none
module discrete_spectrum_sampler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [31:0] energy_in, [47:32] probability_in, [63:48] uniform_value
  input  wire logic [dss_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  wire logic [dss_pkg::OP_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [31:0] energy_out, [38:32] entries_held, [39] zero
  output logic      [dss_pkg::M_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic      [dss_pkg::STATUS_W-1:0]  m_tuser
);
  import dss_pkg::*;

  dss_cmd_t cmd;
  dss_sts_t sts;

  // sequencing: one request at a time, stepping through the table
  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table memory, request latch, count and output register
  dss_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // an accepted request blocks the slave side on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another was in flight");

  // only a successful sample carries a nonzero energy
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[ENERGY_W-1:0] == '0))
    else $error("energy on a failed result");

  // never overwrite a result still waiting on the master side
  assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !(m_tvalid && !m_tready))
    else $error("output register overwritten");

  // a memory write is either a shift or an insert, never both
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_shift && cmd.wr_insert))
    else $error("conflicting table writes");

endmodule
`default_nettype wire

@@ test/tb_discrete_spectrum_sampler.sv @@
`timescale 1ns / 100ps
module tb_discrete_spectrum_sampler;
  import dss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 465;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    status_t             status;
    logic [HELD_W-1:0]   held;
  } reply_t;

  // One row of the directed table. A row with fixed set carries its reply;
  // every other row is checked against the spectrum predictor.
  typedef struct {
    logic [OP_W-1:0]     op;
    logic [ENERGY_W-1:0] energy;
    logic [PROB_W-1:0]   prob;
    logic [UNI_W-1:0]    uni;
    int                  reps;
    bit                  fixed;
    reply_t              reply;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;

  // predicted contents of the spectrum table
  logic [ENERGY_W-1:0] spec_energy [TABLE_DEPTH];
  logic [SUM_W-1:0]    spec_sum    [TABLE_DEPTH];
  int                  spec_count = 0;

  reply_t expected_replies [$];
  int     fault_count = 0;
  int     reply_count = 0;
  int     sent_items  = 0;
  int     burst_left  = 0;
  int     ready_hold  = 0;
  int     idle_cycles = 0;

  step_row_t directed_rows [] = '{
    // empty table: nothing to match
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h1234, 1, 1, '{32'h0, ST_NO_MATCH, 7'd0}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1, '{32'h0, ST_OK, 7'd0}},
    '{OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1, '{32'h0, ST_OK, 7'd0}},
    '{OP_LOAD, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd1}},
    '{OP_LOAD, 32'h0, 16'h0, 16'hFFFF, 1, 1, '{32'h0, ST_OK, 7'd2}},
    '{OP_LOAD, 32'h0005_0000, 16'h8000, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd3}},
    // equal energy goes after the one already held
    '{OP_LOAD, 32'h0005_0000, 16'h1000, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd4}},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h0000, 1, 0, '0},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h8FFF, 1, 0, '0},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h9000, 1, 0, '0},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'hFFFF, 1, 0, '0},
    '{OP_LOAD, 32'h0000_0001, 16'hFFFF, 16'h0, 1, 0, '0},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'hFFFF, 1, 0, '0},
    '{OP_CLEAR, 32'h0, 16'h0, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd0}},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h0, 1, 1, '{32'h0, ST_NO_MATCH, 7'd0}},
    // fill the table with one energy, then push past full
    '{OP_LOAD, 32'h0001_0000, 16'hFFFF, 16'h0, 64, 0, '0},
    '{OP_LOAD, 32'h0000_8000, 16'h0001, 16'h0, 1, 1, '{32'h0, ST_FULL, 7'd64}},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'hFFFF, 1, 0, '0},
    '{OP_SAMPLE, 32'h0, 16'h0, 16'h0, 1, 0, '0},
    '{OP_UNUSED, 32'h0, 16'h0, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd64}},
    '{OP_CLEAR, 32'h0, 16'h0, 16'h0, 1, 1, '{32'h0, ST_OK, 7'd0}}
  };

  discrete_spectrum_sampler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                               input logic [PROB_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Apply one request to the predicted table and return the reply it gives.
  function automatic reply_t spectrum_step(input logic [OP_W-1:0] op,
                                           input logic [ENERGY_W-1:0] energy,
                                           input logic [PROB_W-1:0] prob,
                                           input logic [UNI_W-1:0] uni);
    reply_t           r;
    int               pos;
    logic [SUM_W-1:0] below;
    r.energy = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: spec_count = 0;
      OP_LOAD: begin
        if (spec_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < spec_count && spec_energy[pos] <= energy) pos++;
          for (int i = spec_count; i > pos; i--) begin
            spec_energy[i] = spec_energy[i-1];
            spec_sum[i]    = sum_add(spec_sum[i-1], prob);
          end
          below = (pos > 0) ? spec_sum[pos-1] : '0;
          spec_energy[pos] = energy;
          spec_sum[pos]    = sum_add(below, prob);
          spec_count++;
        end
      end
      OP_SAMPLE: begin
        r.status = ST_NO_MATCH;
        for (int i = 0; i < spec_count; i++) begin
          if (spec_sum[i] > SUM_W'(uni)) begin
            r.energy = spec_energy[i];
            r.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.held = spec_count[HELD_W-1:0];
    return r;
  endfunction

  task automatic report_fault(input string msg);
    $display("mismatch at reply %0d: %s", reply_count, msg);
    fault_count++;
  endtask

  // Present one request from a falling edge, hold it until accepted, and
  // record its reply. Valid stays high while the burst lasts, so the caller
  // must issue the next request without letting time pass.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [ENERGY_W-1:0] energy,
                              input logic [PROB_W-1:0] prob,
                              input logic [UNI_W-1:0] uni,
                              input bit fixed, input reply_t fixed_reply);
    reply_t predicted;
    int     gap;
    s_tuser  = op;
    s_tdata  = {uni, prob, energy};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = spectrum_step(op, energy, prob, uni);
    expected_replies.insert(expected_replies.size(), fixed ? fixed_reply : predicted);
    sent_items++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic hold_until_drained();
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(negedge clk);
  endtask

  // A cleared table loaded with one spectrum, sampled along the way and after.
  task automatic run_spectrum_session();
    int                  loads;
    int                  energy_mode;
    int                  prob_mode;
    logic [ENERGY_W-1:0] e;
    logic [PROB_W-1:0]   p;
    logic [UNI_W-1:0]    u;
    loads       = ($urandom_range(0, 5) == 0) ? $urandom_range(55, 70)
                                              : $urandom_range(1, 14);
    energy_mode = $urandom_range(0, 2);
    prob_mode   = $urandom_range(0, 1);
    send_request(OP_CLEAR, $urandom, PROB_W'($urandom), UNI_W'($urandom), 1'b0, '0);
    for (int i = 0; i < loads + $urandom_range(2, 10); i++) begin
      if (i < loads && $urandom_range(0, 3) != 0) begin
        case (energy_mode)
          0:       e = $urandom;
          1:       e = {16'($urandom_range(0, 7)), 16'h0};   // many ties
          default: e = {16'($urandom_range(0, 255)), 16'($urandom)};
        endcase
        p = prob_mode ? 16'($urandom) : 16'($urandom_range(0, 2000));
        send_request(OP_LOAD, e, p, UNI_W'($urandom), 1'b0, '0);
      end else begin
        // aim most draws inside the running total so they find a match
        if (spec_count > 0 && $urandom_range(0, 3) != 0)
          u = (spec_sum[spec_count-1] > 16'hFFFF) ? 16'($urandom)
            : 16'($urandom_range(0, spec_sum[spec_count-1]));
        else
          u = UNI_W'($urandom);
        send_request(OP_SAMPLE, $urandom, PROB_W'($urandom), u, 1'b0, '0);
      end
    end
  endtask

  // receiver: ready and stall runs of random length, now and then a long run
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      if (m_tready) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 6);
      end else begin
        m_tready   <= 1'b1;
        ready_hold <= ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 10);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // check each reply against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        report_fault($sformatf("unexpected reply energy=%h status=%0d held=%0d",
                               m_tdata[ENERGY_W-1:0], m_tuser,
                               m_tdata[ENERGY_W +: HELD_W]));
      end else begin
        want = expected_replies.pop_front();
        if (m_tdata[ENERGY_W-1:0] != want.energy)
          report_fault($sformatf("energy %h, want %h",
                                 m_tdata[ENERGY_W-1:0], want.energy));
        if (m_tuser != want.status)
          report_fault($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[ENERGY_W +: HELD_W] != want.held)
          report_fault($sformatf("entries held %0d, want %0d",
                                 m_tdata[ENERGY_W +: HELD_W], want.held));
      end
      reply_count++;
    end
  end

  // watchdog: end the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_start;
    int noise_len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps)
        send_request(directed_rows[r].op, directed_rows[r].energy,
                     directed_rows[r].prob, directed_rows[r].uni,
                     directed_rows[r].fixed, directed_rows[r].reply);
    end
    // hold off until the block has answered everything
    hold_until_drained();

    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        run_spectrum_session();
      end else begin
        // noise on whatever the table holds, unused code included
        noise_len = $urandom_range(1, 6);
        repeat (noise_len)
          send_request(OP_W'($urandom_range(0, 3)), $urandom, PROB_W'($urandom),
                       UNI_W'($urandom), 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
